[rtl/mer_pkg.sv]
package mer_pkg;

  localparam int NUM_CHANNELS  = 5;
  localparam int TIMER_BITS    = 16;
  localparam int IN_TIMER_BITS = 16;
  localparam int SCALE_BITS    = 10;
  localparam int DIST_BITS     = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_LIMIT = CFG_IDX_BITS'(1);

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(68);
  localparam logic [DIST_BITS-1:0]  LIMIT_RESET = DIST_BITS'(255);

  // threshold is (limit + 1) * divisor, below 2^18 for any 8-bit limit
  localparam int SCALE_DIV   = 1000;
  localparam int THRESH_BITS = 18;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(256 * SCALE_DIV);

  // floor(p / 1000) = (p * RECIP_MULT) >> RECIP_SHIFT, exact for p < 2^18
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_BITS  = 19;
  localparam logic [RECIP_BITS-1:0] RECIP_MULT = RECIP_BITS'(268436);

  localparam int FIFO_DEPTH = 4;

  typedef logic [DIST_BITS-1:0] dist_t;

  typedef struct packed {
    logic [SCALE_BITS-1:0]  scale;
    logic [DIST_BITS-1:0]   limit;
    logic [THRESH_BITS-1:0] thresh;
  } cfg_t;

  typedef struct packed {
    logic  done;
    dist_t distance;
  } lane_stat_t;

endpackage

[rtl/mer_in_if.sv]
interface mer_in_if;
  logic                                valid;
  logic                                ready;
  logic [mer_pkg::NUM_CHANNELS-1:0]    echo_levels;
  logic [mer_pkg::IN_TIMER_BITS-1:0]   timer_value;

  modport source (output valid, output echo_levels, output timer_value, input ready);
  modport sink   (input valid, input echo_levels, input timer_value, output ready);
endinterface

[rtl/mer_out_if.sv]
interface mer_out_if;
  logic           valid;
  logic           ready;
  mer_pkg::dist_t dist_ch1;
  mer_pkg::dist_t dist_ch2;
  mer_pkg::dist_t dist_ch3;
  mer_pkg::dist_t dist_ch4;
  mer_pkg::dist_t dist_ch5;

  modport source (output valid, output dist_ch1, output dist_ch2, output dist_ch3,
                  output dist_ch4, output dist_ch5, input ready);
  modport sink   (input valid, input dist_ch1, input dist_ch2, input dist_ch3,
                  input dist_ch4, input dist_ch5, output ready);
endinterface

[rtl/mer_cfg_if.sv]
interface mer_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mer_pkg::CFG_IDX_BITS-1:0]    index;
  logic [mer_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/multi_channel_echo_ranger_unit.sv]
// a result is offered once the poll that finds every channel finished is accepted and
// the result has passed the lane multiply stage, then the compare/reciprocal stage
// throughput: one poll per cycle; a finishing poll waits only while the four-entry
// result queue plus the results still in the lane pipes would be full
// reset (rst_n low, synchronous): all channels idle, queue empty, scale 68, limit 255
module multi_channel_echo_ranger_unit #(
  parameter int TIMER_BITS = mer_pkg::TIMER_BITS
) (
  input logic   clk,
  input logic   rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch,
  mer_cfg_if.sink   cfg_ch
);

  logic                          in_accept;
  logic                          all_done;
  logic                          in_ready;
  logic [TIMER_BITS-1:0]         now;
  mer_pkg::cfg_t                 cfg_r;
  mer_pkg::lane_stat_t           stat [mer_pkg::NUM_CHANNELS];
  mer_pkg::dist_t                out_dist [mer_pkg::NUM_CHANNELS];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale  <= mer_pkg::SCALE_RESET;
      cfg_r.limit  <= mer_pkg::LIMIT_RESET;
      cfg_r.thresh <= mer_pkg::THRESH_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == mer_pkg::CFG_SCALE) begin
        cfg_r.scale <= cfg_ch.data[mer_pkg::SCALE_BITS-1:0];
      end else if (cfg_ch.index == mer_pkg::CFG_LIMIT) begin
        cfg_r.limit  <= cfg_ch.data[mer_pkg::DIST_BITS-1:0];
        cfg_r.thresh <= mer_pkg::THRESH_BITS'(
                          (mer_pkg::THRESH_BITS'(cfg_ch.data[mer_pkg::DIST_BITS-1:0]) +
                           mer_pkg::THRESH_BITS'(1)) * mer_pkg::THRESH_BITS'(mer_pkg::SCALE_DIV));
      end
    end
  end

  assign now          = TIMER_BITS'(in_ch.timer_value);
  assign in_ch.ready  = in_ready;
  assign in_accept    = in_ch.valid && in_ready;

  for (genvar g = 0; g < mer_pkg::NUM_CHANNELS; g++) begin : g_lane
    mer_lane #(
      .TIMER_BITS (TIMER_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .accept (in_accept),
      .clear  (all_done),
      .level  (in_ch.echo_levels[g]),
      .now    (now),
      .cfg    (cfg_r),
      .stat   (stat[g])
    );
  end

  mer_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .all_done  (all_done),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_dist  (out_dist)
  );

  assign out_ch.dist_ch1 = out_dist[0];
  assign out_ch.dist_ch2 = out_dist[1];
  assign out_ch.dist_ch3 = out_dist[2];
  assign out_ch.dist_ch4 = out_dist[3];
  assign out_ch.dist_ch5 = out_dist[4];

endmodule

[rtl/mer_lane.sv]
module mer_lane #(
  parameter int TIMER_BITS = mer_pkg::TIMER_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   clear,
  input  logic                   level,
  input  logic [TIMER_BITS-1:0]  now,
  input  mer_pkg::cfg_t          cfg,
  output mer_pkg::lane_stat_t    stat
);

  localparam int PROD_BITS  = TIMER_BITS + mer_pkg::SCALE_BITS;
  localparam int RPROD_BITS = mer_pkg::THRESH_BITS + mer_pkg::RECIP_BITS;

  logic                    timing_r, timing_nxt;
  logic                    done_r, done_nxt;
  logic [TIMER_BITS-1:0]   rise_r, rise_nxt;
  logic [TIMER_BITS-1:0]   width_r, width_nxt;
  logic                    timing_eff, done_eff;

  logic [PROD_BITS-1:0]    prod_r;
  logic [RPROD_BITS-1:0]   rprod;
  mer_pkg::dist_t          quot_r;
  logic                    sat_r;

  // a clearing poll still runs its edge detection on the cleared state
  always_comb begin
    timing_eff = timing_r & ~clear;
    done_eff   = done_r & ~clear;
    timing_nxt = timing_eff;
    done_nxt   = done_eff;
    rise_nxt   = rise_r;
    width_nxt  = width_r;
    if (!done_eff) begin
      if (level && !timing_eff) begin
        rise_nxt   = now;
        timing_nxt = 1'b1;
      end else if (!level && timing_eff) begin
        width_nxt = now - rise_r;
        done_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r <= 1'b0;
      done_r   <= 1'b0;
    end else if (accept) begin
      timing_r <= timing_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rise_r  <= rise_nxt;
      width_r <= width_nxt;
    end
  end

  // distance pipe: width * scale, then compare and reciprocal multiply
  assign rprod = prod_r[mer_pkg::THRESH_BITS-1:0] * mer_pkg::RECIP_MULT;

  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(width_r) * PROD_BITS'(cfg.scale);
    sat_r  <= (prod_r >= PROD_BITS'(cfg.thresh));
    quot_r <= rprod[mer_pkg::RECIP_SHIFT +: mer_pkg::DIST_BITS];
  end

  assign stat.done     = done_r;
  assign stat.distance = sat_r ? cfg.limit : quot_r;

endmodule

[rtl/mer_merge.sv]
module mer_merge (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  all_done,
  input  mer_pkg::lane_stat_t   stat [mer_pkg::NUM_CHANNELS],
  output logic                  out_valid,
  input  logic                  out_ready,
  output mer_pkg::dist_t        out_dist [mer_pkg::NUM_CHANNELS]
);

  localparam int DEPTH = mer_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 3);

  logic [mer_pkg::NUM_CHANNELS-1:0] done_vec;
  logic                  v1_r, v2_r;
  logic                  emit, push, pop;
  logic [CNT_W-1:0]      count_r, occ;
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  mer_pkg::dist_t        mem_r [DEPTH][mer_pkg::NUM_CHANNELS];

  always_comb begin
    for (int i = 0; i < mer_pkg::NUM_CHANNELS; i++) begin
      done_vec[i] = stat[i].done;
    end
  end

  assign all_done = &done_vec;

  // results still in the lane pipes hold a queue slot
  assign occ      = count_r + CNT_W'(v1_r) + CNT_W'(v2_r);
  assign in_ready = !all_done || (occ < CNT_W'(DEPTH));
  assign emit     = in_valid && in_ready && all_done;
  assign push     = v2_r;
  assign out_valid = (count_r != '0);
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      v1_r <= emit;
      v2_r <= v1_r;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < mer_pkg::NUM_CHANNELS; i++) begin
        mem_r[wr_ptr_r][i] <= stat[i].distance;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < mer_pkg::NUM_CHANNELS; i++) begin
      out_dist[i] = mem_r[rd_ptr_r][i];
    end
  end

endmodule

[tb/echo_range_checker.sv]
`timescale 1ns / 100ps

module echo_range_checker
  import mer_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mer_in_if    in_ch,
  mer_out_if   out_ch,
  mer_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending_count
);

  typedef dist_t [NUM_CHANNELS-1:0] ranges_t;

  logic [SCALE_BITS-1:0] scale;
  dist_t                 limit;
  logic [TIMER_BITS-1:0] rise_at  [NUM_CHANNELS];
  logic [TIMER_BITS-1:0] width    [NUM_CHANNELS];
  logic                  timing   [NUM_CHANNELS];
  logic                  finished [NUM_CHANNELS];
  ranges_t               range_q  [$];

  function automatic dist_t scaled_distance(input logic [TIMER_BITS-1:0] w);
    logic [31:0] prod;
    prod = (32'(w) * 32'(scale)) / 32'(SCALE_DIV);
    if (prod > 32'(limit)) return limit;
    return dist_t'(prod);
  endfunction

  task automatic clear_channels();
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      rise_at[i]  = '0;
      width[i]    = '0;
      timing[i]   = 1'b0;
      finished[i] = 1'b0;
    end
  endtask

  task automatic track_poll(input logic [NUM_CHANNELS-1:0] lv,
                            input logic [IN_TIMER_BITS-1:0] tv);
    logic [TIMER_BITS-1:0] now;
    logic                  all_done;
    ranges_t               r;
    now = tv[TIMER_BITS-1:0];
    all_done = 1'b1;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!finished[i]) all_done = 1'b0;
    end
    // emission is decided before this poll's levels are looked at
    if (all_done) begin
      for (int i = 0; i < NUM_CHANNELS; i++) r[i] = scaled_distance(width[i]);
      range_q.push_back(r);
      clear_channels();
    end
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (!finished[i]) begin
        if (lv[i] && !timing[i]) begin
          rise_at[i] = now;
          timing[i]  = 1'b1;
        end else if (!lv[i] && timing[i]) begin
          width[i]    = now - rise_at[i];
          finished[i] = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    ranges_t got;
    ranges_t want;
    if (!rst_n) begin
      clear_channels();
      scale = SCALE_RESET;
      limit = LIMIT_RESET;
      range_q.delete();
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.dist_ch5, out_ch.dist_ch4, out_ch.dist_ch3,
               out_ch.dist_ch2, out_ch.dist_ch1};
        if (range_q.size() == 0) begin
          $error("result beat with no finishing poll behind it");
          fail_count++;
        end else begin
          want = range_q.pop_front();
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (got[i] !== want[i]) begin
              $error("dist_ch%0d: expected %0d, got %0d", i + 1, want[i], got[i]);
              fail_count++;
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_SCALE: scale = cfg_ch.data[SCALE_BITS-1:0];
          CFG_LIMIT: limit = cfg_ch.data[DIST_BITS-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) track_poll(in_ch.echo_levels, in_ch.timer_value);
    end
    pending_count = range_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import mer_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = CFG_IDX_BITS'(3);

  localparam int NUM_PHASES    = 8;
  localparam int PHASE_POLLS   = 119;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 100000;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     calm;
  logic                     hold_req;
  logic [NUM_CHANNELS-1:0]  levels;
  logic [IN_TIMER_BITS-1:0] ticks;
  int                       fail_count;
  int                       pending_count;
  int                       cycle_count = 0;

  mer_in_if  in_ch ();
  mer_out_if out_ch ();
  mer_cfg_if cfg_ch ();

  multi_channel_echo_ranger_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  echo_range_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_channel_echo_ranger_unit: mismatch");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off when asked
  initial begin
    int   gap;
    logic hold_taken;
    hold_taken = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        gap = HOLD_CYCLES;
        hold_taken = 1'b1;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 3);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_poll(input logic [NUM_CHANNELS-1:0] lv,
                           input logic [IN_TIMER_BITS-1:0] tv);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.echo_levels <= lv;
    in_ch.timer_value <= tv;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  // let every result out and the pipe go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
  endtask

  task automatic set_ranging(input logic [SCALE_BITS-1:0] sc, input dist_t lim);
    settle();
    write_reg(CFG_SCALE, CFG_DATA_BITS'(sc));
    // upper data bits are don't-care for the limit
    write_reg(CFG_LIMIT, {(CFG_DATA_BITS - DIST_BITS)'($urandom), lim});
    if ($urandom_range(0, 1) == 1)
      write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                CFG_DATA_BITS'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_poll();
    logic [NUM_CHANNELS-1:0] flips;
    int                      pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      // pulse trains: each pin toggles now and then
      for (int i = 0; i < NUM_CHANNELS; i++) flips[i] = ($urandom_range(0, 2) == 0);
      levels = levels ^ flips;
    end else begin
      levels = NUM_CHANNELS'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 60)      ticks = ticks + IN_TIMER_BITS'($urandom_range(0, 30));
    else if (pick < 88) ticks = ticks + IN_TIMER_BITS'($urandom_range(0, 2500));
    else if (pick < 96) ticks = ticks + IN_TIMER_BITS'($urandom);
    else                ticks = IN_TIMER_BITS'($urandom);
    send_poll(levels, ticks);
  endtask

  initial begin
    calm     = 1'b0;
    hold_req = 1'b0;
    levels   = '0;
    ticks    = '0;
    rst_n    = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.echo_levels = '0;
    in_ch.timer_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SCALE;
    cfg_ch.data  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // timer wrap, finished channels ignoring their pins while the rest run on
    send_poll(5'b00000, 16'd0);
    send_poll(5'b11111, 16'd65530);
    send_poll(5'b11110, 16'd5);
    send_poll(5'b11111, 16'd100);
    send_poll(5'b00001, 16'd3100);
    send_poll(5'b00000, 16'd3101);
    // longest width, clipped at the reset limit
    send_poll(5'b11111, 16'd0);
    send_poll(5'b00000, 16'hFFFF);
    send_poll(5'b10101, 16'hFFFF);

    // zero scale gives all-zero distances
    set_ranging(10'd0, 8'd255);
    send_poll(5'b11111, 16'd100);
    send_poll(5'b00000, 16'd4000);
    send_poll(5'b00000, 16'd4001);

    // largest scale, limit below some distances
    set_ranging(10'd1023, 8'd100);
    send_poll(5'b11111, 16'd200);
    send_poll(5'b01010, 16'd201);
    send_poll(5'b00000, 16'd400);
    send_poll(5'b11111, 16'd401);

    // zero limit
    set_ranging(10'd1, 8'd0);
    send_poll(5'b00000, 16'hFFFF);
    send_poll(5'b00000, 16'd0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_ranging(SCALE_RESET, LIMIT_RESET);
        1: set_ranging(10'd1023, 8'd255);
        2: set_ranging(10'd1, 8'd0);
        3: set_ranging(10'd1023, 8'd0);
        4: set_ranging(SCALE_BITS'($urandom_range(1, 1023)), dist_t'($urandom));
        5: set_ranging(10'd0, 8'd37);
        6: set_ranging(10'd250, 8'd255);
        default: set_ranging(SCALE_BITS'($urandom_range(1, 1023)), dist_t'($urandom));
      endcase
      calm = (ph == 1 || ph == 4 || ph == 6);
      // back-pressure run: sender keeps offering while results pile up
      if (ph == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_POLLS; n++) random_poll();
    end

    settle();
    if (fail_count == 0) begin
      $display("multi_channel_echo_ranger_unit: match");
    end else begin
      $display("multi_channel_echo_ranger_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mer_pkg.sv
rtl/mer_in_if.sv
rtl/mer_out_if.sv
rtl/mer_cfg_if.sv
rtl/mer_lane.sv
rtl/mer_merge.sv
rtl/multi_channel_echo_ranger_unit.sv
tb/echo_range_checker.sv
tb/tb.sv
